[rtl/core/updec_pkg.sv]
// ----------------------------------------------------------------------------
// updec_pkg: shared types and helpers for the URL percent decoder
// Payload structs, character codes, register map and digit conversion.
// ----------------------------------------------------------------------------
package updec_pkg;

	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;

	// Word index of each configuration register (byte address / 4)
	localparam logic [0:0] REG_PLUS_TO_SPACE = 1'b0;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// Results of one decoded byte, handed to the output queue
	typedef struct packed {
		logic [1:0] count;
		out_item_t  item0;
		out_item_t  item1;
	} dec_res_t;

	// 8-bit unsigned digit value, 8'hFF for a non-digit
	function automatic logic [7:0] digit_value(input logic [7:0] c);
		logic [7:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			v = c - 8'h61 + 8'd10;
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			v = c - 8'h41 + 8'd10;
		end else begin
			v = 8'hFF;
		end
		return v;
	endfunction

	function automatic logic [7:0] plain_byte(input logic [7:0] c, input logic plus_sp);
		logic [7:0] v;
		v = (c == CH_PLUS && plus_sp) ? CH_SPACE : c;
		return v;
	endfunction

endpackage

[rtl/core/updec_decode.sv]
// ----------------------------------------------------------------------------
// updec_decode: input register and escape decode
// Holds one raw byte, tracks the escape phase and emits zero to two results.
// ----------------------------------------------------------------------------
module updec_decode
	import updec_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	input  logic       plus_to_space,
	input  logic [1:0] slots_free,
	output dec_res_t   res
);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_FIRST = 2'd2
	} phase_t;

	phase_t     phase_q;
	phase_t     phase_nxt;
	logic [3:0] first_digit_q;   // only the low nibble of the first digit matters
	logic       valid_s1;
	in_item_t   item_s1;
	dec_res_t   dec;
	logic       drain;
	logic [7:0] dv_b;

	assign dv_b = digit_value(item_s1.in_byte);

	always_comb begin
		dec       = '0;
		phase_nxt = PH_IDLE;
		case (phase_q)
			PH_PCT: begin
				if (item_s1.in_last) begin
					// escape cut short: literal '%' then the byte as plain
					dec.count = 2'd2;
					dec.item0 = '{out_byte: CH_PERCENT, out_last: 1'b0};
					dec.item1 = '{out_byte: plain_byte(item_s1.in_byte, plus_to_space),
						out_last: 1'b1};
				end else begin
					phase_nxt = PH_FIRST;
				end
			end
			PH_FIRST: begin
				dec.count = 2'd1;
				dec.item0 = '{out_byte: {first_digit_q, 4'b0000} + dv_b,
					out_last: item_s1.in_last};
			end
			default: begin
				if (item_s1.in_byte == CH_PERCENT) begin
					if (item_s1.in_last) begin
						dec.count = 2'd1;
						dec.item0 = '{out_byte: CH_PERCENT, out_last: 1'b1};
					end else begin
						phase_nxt = PH_PCT;
					end
				end else begin
					dec.count = 2'd1;
					dec.item0 = '{out_byte: plain_byte(item_s1.in_byte, plus_to_space),
						out_last: item_s1.in_last};
				end
			end
		endcase
	end

	assign drain     = valid_s1 && (dec.count <= slots_free);
	assign in_ready  = !valid_s1 || drain;
	assign res.count = drain ? dec.count : 2'd0;
	assign res.item0 = dec.item0;
	assign res.item1 = dec.item1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			phase_q       <= PH_IDLE;
			first_digit_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (drain) begin
				phase_q <= phase_nxt;
				if (phase_q == PH_PCT && !item_s1.in_last) begin
					first_digit_q <= dv_b[3:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		drain && item_s1.in_last |=> phase_q == PH_IDLE)
		else $error("escape still pending after a last byte");

	a_no_result_on_open: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && dec.count == 2'd0 |-> !item_s1.in_last)
		else $error("last byte produced no result");

	a_two_only_short: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && dec.count == 2'd2 |-> phase_q == PH_PCT && item_s1.in_last)
		else $error("two results outside a cut-short escape");

endmodule

[rtl/core/url_percent_decoder.sv]
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming URL percent decoder
// Decodes %XX escapes, optionally maps '+' to space, one byte per cycle.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_item) takes one encoded byte per
// transfer, in_last on the final byte of a string. Output channel
// (out_valid/out_ready/out_item) gives decoded bytes with out_last.
// Path: each byte is held in the input register and decoded from it; its
// results are registered into the two-entry output queue, whose head entry
// drives out_item.
// Throughput: one byte per cycle while the output queue has room. A '%' cut
// short by in_last yields two results from one byte; it leaves the input
// register once the queue, with a same-cycle output transfer counted, has
// two free entries, and its second result goes out after the first.
// When the receiver stalls the queue fills and in_ready drops; a byte held
// in the input register stays there until the queue has room.
// Reset (arst_n low) empties the queue, clears the escape phase and
// sets plus_to_space to 0. The APB port holds one register, plus_to_space,
// at address 0; write it only while the block is idle.
// ----------------------------------------------------------------------------
module url_percent_decoder
	import updec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic       plus_to_space_q;
	out_item_t  slot0_q;
	out_item_t  slot1_q;
	logic [1:0] cnt_q;
	logic [1:0] rem_cnt;
	logic [1:0] slots_free;
	logic       pop;
	dec_res_t   res;
	out_item_t  e0;
	out_item_t  e1;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1:2] == REG_PLUS_TO_SPACE) ?
		{{(DATA_W-1){1'b0}}, plus_to_space_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plus_to_space_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
			paddr[ADDR_W-1:2] == REG_PLUS_TO_SPACE) begin
			plus_to_space_q <= pwdata[0];
		end
	end

	updec_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_item       (in_item),
		.plus_to_space (plus_to_space_q),
		.slots_free    (slots_free),
		.res           (res)
	);

	// two-entry output queue
	assign out_valid  = (cnt_q != 2'd0);
	assign out_item   = slot0_q;
	assign pop        = out_valid && out_ready;
	assign rem_cnt    = cnt_q - {1'b0, pop};
	assign slots_free = 2'd2 - rem_cnt;

	always_comb begin
		e0 = slot0_q;
		e1 = slot1_q;
		case (rem_cnt)
			2'd0: begin
				e0 = res.item0;
				e1 = res.item1;
			end
			2'd1: begin
				e0 = pop ? slot1_q : slot0_q;
				e1 = res.item0;
			end
			default: begin
				e0 = slot0_q;
				e1 = slot1_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= rem_cnt + res.count;
		end
	end

	always_ff @(posedge clk) begin
		slot0_q <= e0;
		slot1_q <= e1;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue over capacity");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		res.count != 2'd0 |-> res.count <= 2'd2 - rem_cnt)
		else $error("decode pushed into a full queue");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pop && cnt_q == 2'd2 |=> out_valid)
		else $error("queued result lost after transfer");

endmodule
